>>> rtl/itp_pkg.sv
// Shared types, codes and helpers for the infix-to-postfix converter.
`default_nettype none

package itp_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int KIND_W          = 3;
   localparam int VALUE_W         = 31;

   // input token kinds
   localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PLUS   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MINUS  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TIMES  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DIVIDE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd7;

   // result kinds
   localparam logic [KIND_W-1:0] OUT_NONE   = 3'd0;
   localparam logic [KIND_W-1:0] OUT_NUMBER = 3'd1;

   // result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_MALFORMED   = 3'd1;
   localparam logic [2:0] ST_EXTRA_CLOSE = 3'd2;
   localparam logic [2:0] ST_EXTRA_OPEN  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW    = 3'd4;
   localparam logic [2:0] ST_SKIPPED     = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK,
      S_RELOAD
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [VALUE_W-1:0] number_value;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  out_kind;
      logic [VALUE_W-1:0] out_value;
      logic [2:0]         status;
      logic               last;
   } rsp_item_type;

   function automatic logic is_op(input logic [KIND_W-1:0] k);
      return (k == KIND_PLUS) || (k == KIND_MINUS) || (k == KIND_TIMES) ||
             (k == KIND_DIVIDE);
   endfunction

   function automatic logic [1:0] prec(input logic [KIND_W-1:0] k);
      logic [1:0] p;
      case (k) inside
         KIND_PLUS, KIND_MINUS:   p = 2'd1;
         KIND_TIMES, KIND_DIVIDE: p = 2'd2;
         default:                 p = 2'd0;
      endcase
      return p;
   endfunction

   // popped operator kind -> result kind
   function automatic logic [KIND_W-1:0] op_out_kind(input logic [KIND_W-1:0] k);
      return KIND_W'(k + 3'd1);
   endfunction

   function automatic logic bad_pair(input logic [KIND_W-1:0] p,
                                     input logic [KIND_W-1:0] t);
      return ((p == KIND_NUMBER) && (t == KIND_NUMBER)) ||
             ((p == KIND_OPEN)   && (t == KIND_CLOSE))  ||
             (is_op(p)           && is_op(t))           ||
             ((p == KIND_NUMBER) && (t == KIND_OPEN))   ||
             ((p == KIND_OPEN)   && is_op(t))           ||
             (is_op(p)           && (t == KIND_CLOSE))  ||
             ((p == KIND_CLOSE)  && (t == KIND_NUMBER));
   endfunction

endpackage

`default_nettype wire

>>> rtl/itp_req_if.sv
// Token request channel: valid/ready handshake with an infix token payload.
`default_nettype none

interface itp_req_if import itp_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/itp_rsp_if.sv
// Result channel: valid/ready handshake with a postfix token payload.
`default_nettype none

interface itp_rsp_if import itp_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/infix_to_postfix_converter_unit.sv
// Infix-to-postfix converter: operator stack and pop sequencer.
//
//   Channel   Dir   Payload                                   Handshake
//   req_bus   in    token_kind, number_value                  valid/ready
//   rsp_bus   out   out_kind, out_value, status, last          valid/ready
//
// Each token is accepted, then takes a sequencer step; every operator popped
// is emitted and then the cached second-from-top entry is refilled from the
// stack RAM's registered read port.
// A closing parenthesis that pops its open bracket also passes through the refill state.
// The block accepts one token at a time; the output register lets the next
// token in while the final result still waits. A stalled result holds the
// sequencer. Synchronous reset empties the stack; the RAM needs no clearing.
`default_nettype none

module infix_to_postfix_converter_unit import itp_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   itp_req_if.sink   req_bus,
   itp_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [KIND_W-1:0]  tok_kind_ff, tok_kind_in;
   logic [VALUE_W-1:0] tok_value_ff, tok_value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [KIND_W-1:0]  top_ff, top_in;
   logic [KIND_W-1:0]  below_ff, below_in;
   logic [KIND_W-1:0]  prev_ff, prev_in;
   logic               first_ff, first_in;
   logic               failed_ff, failed_in;
   logic               emitted_ff, emitted_in;
   logic               done_ff, done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic               emit_req;
   rsp_item_type       emit_item;
   logic               out_free;
   logic               has_top, top_open, two_plus, full;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [KIND_W-1:0]  ram_wdata, ram_rdata;

   itp_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign has_top  = (count_ff != '0);
   assign top_open = (top_ff == KIND_OPEN);
   assign two_plus = (count_ff >= CW'(2));
   assign full     = (count_ff >= CW'(STACK_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         prev_ff      <= KIND_NUMBER;
         first_ff     <= 1'b1;
         failed_ff    <= 1'b0;
         emitted_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         failed_ff    <= failed_in;
         emitted_ff   <= emitted_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_kind_ff  <= tok_kind_in;
      tok_value_ff <= tok_value_in;
      top_ff       <= top_in;
      below_ff     <= below_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      tok_kind_in  = tok_kind_ff;
      tok_value_in = tok_value_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      below_in     = below_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      failed_in    = failed_ff;
      emitted_in   = emitted_ff;
      done_in      = done_ff;
      emit_req     = 1'b0;
      emit_item    = '0;
      ram_we       = 1'b0;
      ram_waddr    = AW'(count_ff);
      ram_wdata    = tok_kind_ff;
      // entry that becomes second-from-top after a pop
      ram_raddr    = AW'(count_ff - CW'(3));

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               tok_kind_in  = req_bus.data.token_kind;
               tok_value_in = req_bus.data.number_value;
               emitted_in   = 1'b0;
               state_in     = S_WORK;
            end
         end

         S_RELOAD: begin
            below_in = ram_rdata;
            state_in = done_ff ? S_IDLE : S_WORK;
         end

         S_WORK: begin
            if (failed_ff) begin
               emit_req  = 1'b1;
               emit_item = '{OUT_NONE, '0, ST_SKIPPED, 1'b1};
               if (tok_kind_ff == KIND_END) begin
                  count_in  = '0;
                  prev_in   = KIND_NUMBER;
                  first_in  = 1'b1;
                  failed_in = 1'b0;
               end
               state_in = S_IDLE;
            end else if (tok_kind_ff == KIND_END) begin
               emit_req = 1'b1;
               if (has_top && !top_open) begin
                  emit_item = '{op_out_kind(top_ff), '0, ST_OK, 1'b0};
                  count_in  = count_ff - CW'(1);
                  top_in    = below_ff;
                  done_in   = 1'b0;
                  state_in  = S_RELOAD;
               end else begin
                  emit_item = '{OUT_NONE, '0, has_top ? ST_EXTRA_OPEN : ST_OK, 1'b1};
                  count_in  = '0;
                  prev_in   = KIND_NUMBER;
                  first_in  = 1'b1;
                  failed_in = 1'b0;
                  state_in  = S_IDLE;
               end
            end else if (!first_ff && bad_pair(prev_ff, tok_kind_ff)) begin
               emit_req  = 1'b1;
               emit_item = '{OUT_NONE, '0, ST_MALFORMED, 1'b1};
               failed_in = 1'b1;
               state_in  = S_IDLE;
            end else if (tok_kind_ff == KIND_NUMBER) begin
               emit_req  = 1'b1;
               emit_item = '{OUT_NUMBER, tok_value_ff, ST_OK, 1'b1};
               prev_in   = tok_kind_ff;
               first_in  = 1'b0;
               state_in  = S_IDLE;
            end else if (tok_kind_ff == KIND_OPEN) begin
               emit_req = 1'b1;
               if (full) begin
                  emit_item = '{OUT_NONE, '0, ST_OVERFLOW, 1'b1};
                  failed_in = 1'b1;
               end else begin
                  emit_item = '{OUT_NONE, '0, ST_OK, 1'b1};
                  ram_we    = 1'b1;
                  count_in  = count_ff + CW'(1);
                  below_in  = top_ff;
                  top_in    = tok_kind_ff;
               end
               prev_in  = tok_kind_ff;
               first_in = 1'b0;
               state_in = S_IDLE;
            end else if (tok_kind_ff == KIND_CLOSE) begin
               if (has_top && !top_open) begin
                  // last pop when the open bracket sits just below
                  emit_req   = 1'b1;
                  emit_item  = '{op_out_kind(top_ff), '0, ST_OK,
                                 two_plus && (below_ff == KIND_OPEN)};
                  count_in   = count_ff - CW'(1);
                  top_in     = below_ff;
                  emitted_in = 1'b1;
                  done_in    = 1'b0;
                  state_in   = S_RELOAD;
               end else if (!has_top) begin
                  emit_req  = 1'b1;
                  emit_item = '{OUT_NONE, '0, ST_EXTRA_CLOSE, 1'b1};
                  failed_in = 1'b1;
                  prev_in   = tok_kind_ff;
                  first_in  = 1'b0;
                  state_in  = S_IDLE;
               end else begin
                  // discard the matching open bracket
                  emit_req  = !emitted_ff;
                  emit_item = '{OUT_NONE, '0, ST_OK, 1'b1};
                  count_in  = count_ff - CW'(1);
                  top_in    = below_ff;
                  prev_in   = tok_kind_ff;
                  first_in  = 1'b0;
                  done_in   = 1'b1;
                  state_in  = S_RELOAD;
               end
            end else begin
               if (has_top && (prec(tok_kind_ff) <= prec(top_ff))) begin
                  emit_req   = 1'b1;
                  emit_item  = '{op_out_kind(top_ff), '0, ST_OK,
                                 !two_plus || (prec(tok_kind_ff) > prec(below_ff))};
                  count_in   = count_ff - CW'(1);
                  top_in     = below_ff;
                  emitted_in = 1'b1;
                  done_in    = 1'b0;
                  state_in   = S_RELOAD;
               end else begin
                  if (full) begin
                     emit_req  = 1'b1;
                     emit_item = '{OUT_NONE, '0, ST_OVERFLOW, 1'b1};
                     failed_in = 1'b1;
                  end else begin
                     emit_req  = !emitted_ff;
                     emit_item = '{OUT_NONE, '0, ST_OK, 1'b1};
                     ram_we    = 1'b1;
                     count_in  = count_ff + CW'(1);
                     below_in  = top_ff;
                     top_in    = tok_kind_ff;
                  end
                  prev_in  = tok_kind_ff;
                  first_in = 1'b0;
                  state_in = S_IDLE;
               end
            end

            // result register still occupied: hold the step
            if (emit_req && !out_free) begin
               state_in   = state_ff;
               count_in   = count_ff;
               top_in     = top_ff;
               below_in   = below_ff;
               prev_in    = prev_ff;
               first_in   = first_ff;
               failed_in  = failed_ff;
               emitted_in = emitted_ff;
               done_in    = done_ff;
               ram_we     = 1'b0;
               emit_req   = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_req) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_item;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> dv/postfix_checker.sv
// Checker for the infix-to-postfix converter: predicts postfix output and compares it.
`timescale 1ns / 100ps

module postfix_checker import itp_pkg::*; #(
   parameter int DEPTH = STACK_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   itp_req_if   req_mon,
   itp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_results
);

   typedef enum logic [2:0] {
      CL_NUM,
      CL_OP,
      CL_OPEN,
      CL_CLOSE,
      CL_END
   } token_class_type;

   rsp_item_type      postfix_q[$];
   logic [KIND_W-1:0] op_stack[DEPTH];
   int unsigned       stack_fill;
   logic [KIND_W-1:0] prev_kind;
   logic              at_first;
   logic              in_error;
   int                fail_total = 0;

   assign fail_count = fail_total;

   function automatic token_class_type class_of(input logic [KIND_W-1:0] k);
      token_class_type c;
      case (k) inside
         KIND_NUMBER:                                     c = CL_NUM;
         KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIVIDE:  c = CL_OP;
         KIND_OPEN:                                       c = CL_OPEN;
         KIND_CLOSE:                                      c = CL_CLOSE;
         default:                                         c = CL_END;
      endcase
      return c;
   endfunction

   function automatic int binding_rank(input logic [KIND_W-1:0] k);
      int r;
      case (k) inside
         KIND_TIMES, KIND_DIVIDE: r = 2;
         KIND_PLUS, KIND_MINUS:   r = 1;
         default:                 r = 0;
      endcase
      return r;
   endfunction

   function automatic logic illegal_after(input logic [KIND_W-1:0] p,
                                          input logic [KIND_W-1:0] t);
      token_class_type cp;
      token_class_type ct;
      logic bad;
      cp  = class_of(p);
      ct  = class_of(t);
      bad = 1'b0;
      case (cp)
         CL_NUM:   bad = (ct == CL_NUM) || (ct == CL_OPEN);
         CL_OPEN:  bad = (ct == CL_CLOSE) || (ct == CL_OP);
         CL_OP:    bad = (ct == CL_OP) || (ct == CL_CLOSE);
         CL_CLOSE: bad = (ct == CL_NUM);
         default:  bad = 1'b0;
      endcase
      return bad;
   endfunction

   task automatic restart_expression();
      stack_fill = 0;
      prev_kind  = KIND_NUMBER;
      at_first   = 1'b1;
      in_error   = 1'b0;
   endtask

   task automatic add_result(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                             input logic [2:0] status, input logic last);
      rsp_item_type r;
      r.out_kind  = kind;
      r.out_value = value;
      r.status    = status;
      r.last      = last;
      postfix_q.insert(postfix_q.size(), r);
   endtask

   // result codes for operators sit one above their token codes
   task automatic pop_operator();
      add_result(op_stack[stack_fill-1] + 3'd1, '0, ST_OK, 1'b0);
      stack_fill--;
   endtask

   task automatic predict_token(input req_item_type tok);
      logic [KIND_W-1:0] k;
      logic [2:0]        fault;
      int                q_start;
      k       = tok.token_kind;
      fault   = ST_OK;
      q_start = postfix_q.size();

      if (in_error) begin
         if (k == KIND_END)
            restart_expression();
         add_result(OUT_NONE, '0, ST_SKIPPED, 1'b1);
         return;
      end

      if (k == KIND_END) begin
         while (stack_fill > 0) begin
            if (op_stack[stack_fill-1] == KIND_OPEN) begin
               fault = ST_EXTRA_OPEN;
               break;
            end
            pop_operator();
         end
         add_result(OUT_NONE, '0, fault, 1'b1);
         restart_expression();
         return;
      end

      if (!at_first && illegal_after(prev_kind, k)) begin
         in_error = 1'b1;
         add_result(OUT_NONE, '0, ST_MALFORMED, 1'b1);
         return;
      end

      if (k == KIND_NUMBER) begin
         add_result(OUT_NUMBER, tok.number_value, ST_OK, 1'b1);
      end else begin
         if (k == KIND_CLOSE) begin
            while (stack_fill > 0 && op_stack[stack_fill-1] != KIND_OPEN)
               pop_operator();
            if (stack_fill == 0)
               fault = ST_EXTRA_CLOSE;
            else
               stack_fill--;
         end else begin
            if (k != KIND_OPEN)
               while (stack_fill > 0 &&
                      binding_rank(k) <= binding_rank(op_stack[stack_fill-1]))
                  pop_operator();
            if (stack_fill >= DEPTH) begin
               fault = ST_OVERFLOW;
            end else begin
               op_stack[stack_fill] = k;
               stack_fill++;
            end
         end

         if (fault != ST_OK) begin
            in_error = 1'b1;
            add_result(OUT_NONE, '0, fault, 1'b1);
         end else if (postfix_q.size() == q_start) begin
            add_result(OUT_NONE, '0, ST_OK, 1'b1);
         end else begin
            postfix_q[postfix_q.size()-1].last = 1'b1;
         end
      end

      prev_kind = k;
      at_first  = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         restart_expression();
         postfix_q.delete();
      end else begin
         // results first: one accepted in this cycle cannot stem from this cycle's request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (postfix_q.size() == 0) begin
               $error("unexpected result: out_kind %0d out_value %0d status %0d last %0d",
                      got.out_kind, got.out_value, got.status, got.last);
               fail_total++;
            end else begin
               want = postfix_q.pop_front();
               if (got.out_kind !== want.out_kind) begin
                  $error("out_kind: expected %0d, actual %0d", want.out_kind, got.out_kind);
                  fail_total++;
               end
               if (got.out_value !== want.out_value) begin
                  $error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
                  fail_total++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fail_total++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, got.last);
                  fail_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_token(req_mon.data);
      end
      pending_results = postfix_q.size();
   end

endmodule

>>> dv/tb.sv
// Top-level testbench for the infix-to-postfix converter: stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import itp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_results;
   int   sent_items = 0;
   int   cycle_count = 0;
   int   stall_left = 0;
   logic idle_on = 1'b1;

   logic [KIND_W-1:0] op_codes[4] = '{KIND_PLUS, KIND_MINUS, KIND_TIMES, KIND_DIVIDE};

   itp_req_if req_bus();
   itp_rsp_if rsp_bus();

   infix_to_postfix_converter_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   postfix_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result-side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 14);
      rsp_bus.ready <= (stall_left == 0);
   end

   task automatic send_token(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.data.token_kind   <= kind;
      req_bus.data.number_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      sent_items++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = '1;
         default: v = VALUE_W'($urandom());
      endcase
      return v;
   endfunction

   task automatic send_number();
      send_token(KIND_NUMBER, pick_value());
   endtask

   task automatic send_op();
      send_token(op_codes[$urandom_range(0, 3)], pick_value());
   endtask

   // hold the sender until every outstanding result has been taken
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
   endtask

   // well-formed expression with random nesting
   task automatic send_expression(input int max_tokens);
      int depth;
      int count;
      logic want_operand;
      depth        = 0;
      count        = 0;
      want_operand = 1'b1;
      forever begin
         if (want_operand) begin
            if (depth < 6 && count < max_tokens && $urandom_range(0, 3) == 0) begin
               send_token(KIND_OPEN, pick_value());
               depth++;
            end else begin
               send_number();
               want_operand = 1'b0;
            end
         end else if (count >= max_tokens && depth == 0) begin
            break;
         end else if (depth > 0 && (count >= max_tokens || $urandom_range(0, 9) < 3)) begin
            send_token(KIND_CLOSE, pick_value());
            depth--;
         end else begin
            send_op();
            want_operand = 1'b1;
         end
         count++;
      end
      send_token(KIND_END, pick_value());
   endtask

   // random token soup, usually broken
   task automatic send_noise();
      repeat ($urandom_range(2, 8))
         send_token(KIND_W'($urandom_range(KIND_NUMBER, KIND_END)), pick_value());
      send_token(KIND_END, pick_value());
   endtask

   // deep nesting to run the operator stack up to and past full
   task automatic send_deep();
      int opens;
      opens = $urandom_range(STACK_DEPTH_DEF - 2, STACK_DEPTH_DEF + 1);
      repeat (opens) send_token(KIND_OPEN, pick_value());
      send_number();
      repeat ($urandom_range(1, 4)) begin
         send_op();
         send_number();
      end
      repeat (opens) send_token(KIND_CLOSE, pick_value());
      send_token(KIND_END, pick_value());
   endtask

   initial begin
      int style;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 0 + max * ( 5 - 9 ) / 3 end
      send_token(KIND_NUMBER, '0);
      send_token(KIND_PLUS, '0);
      send_token(KIND_NUMBER, '1);
      send_token(KIND_TIMES, '0);
      send_token(KIND_OPEN, '1);
      send_token(KIND_NUMBER, 31'd5);
      send_token(KIND_MINUS, '0);
      send_token(KIND_NUMBER, 31'd9);
      send_token(KIND_CLOSE, '0);
      send_token(KIND_DIVIDE, '1);
      send_token(KIND_NUMBER, 31'd3);
      send_token(KIND_END, '0);
      // stray close, then skipped requests until end
      send_token(KIND_CLOSE, '0);
      send_token(KIND_NUMBER, 31'd1);
      send_token(KIND_END, '1);
      // unmatched open at end
      send_token(KIND_OPEN, '0);
      send_token(KIND_END, '0);
      // two numbers in a row
      send_token(KIND_NUMBER, 31'd2);
      send_token(KIND_NUMBER, 31'd4);
      send_token(KIND_END, '0);
      wait_drained();

      while (sent_items < 60) begin
         idle_on = ($urandom_range(0, 3) != 0);
         style   = $urandom_range(0, 19);
         if (style < 12) begin
            send_expression($urandom_range(1, 12));
         end else if (style < 15) begin
            send_noise();
         end else if (style < 17) begin
            send_deep();
         end else begin
            wait_drained();
            send_expression($urandom_range(1, 8));
         end
      end

      idle_on = 1'b0;
      repeat (2) send_expression($urandom_range(3, 8));

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
